/* hdl/charlieplex_lit_list_scanner_macros.svh */
// assertion macros shared by the scanner rtl
// expects signals named clock and reset in the including module
`ifndef CHARLIEPLEX_LIT_LIST_SCANNER_MACROS_SVH
`define CHARLIEPLEX_LIT_LIST_SCANNER_MACROS_SVH

// same-cycle implication, disabled during reset
`define CPLS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cpls same-cycle check failed");

// next-cycle implication, disabled during reset
`define CPLS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cpls next-cycle check failed");

`endif

/* hdl/cpls_pkg.sv */
// shared constants, types and pin mapping functions for the lit list scanner
// no dependencies
package cpls_pkg;

   // grid geometry
   localparam int GRID_SIZE   = 10;
   localparam int CELLS       = GRID_SIZE * GRID_SIZE;
   localparam int CELL_BITS   = $clog2(CELLS);
   localparam int COUNT_BITS  = $clog2(CELLS + 1);
   localparam int COORD_BITS  = 4;
   localparam int ENTRY_BITS  = 2 * COORD_BITS;

   // fixed field widths
   localparam int OP_BITS          = 2;
   localparam int PIXEL_INDEX_BITS = 7;
   localparam int PIN_BITS         = 16;
   localparam int BUDGET_BITS      = 8;
   localparam int LIT_TOTAL_BITS   = 7;

   // shared divider sizes
   localparam int DIVIDEND_BITS = BUDGET_BITS;
   localparam int DIVISOR_BITS  = COUNT_BITS;
   localparam int DIV_STEP_BITS = $clog2(DIVIDEND_BITS);

   localparam logic [BUDGET_BITS-1:0] PERIOD_RESET = 8'd137;

   // drive lines and the pin each one lands on
   localparam int MAP_LINES = 11;
   localparam logic [3:0] PIN_MAP [MAP_LINES] = '{
      4'd0, 4'd1, 4'd2, 4'd6, 4'd7, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
   };

   typedef enum logic [OP_BITS-1:0] {
      OP_WRITE  = 2'd0,
      OP_COMMIT = 2'd1,
      OP_TICK   = 2'd2
   } op_type;

   localparam logic RES_SCAN   = 1'b0;
   localparam logic RES_REPORT = 1'b1;

   typedef struct packed {
      logic                     start;
      logic [DIVIDEND_BITS-1:0] dividend;
      logic [DIVISOR_BITS-1:0]  divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // translate a drive line vector to physical pins
   function automatic logic [PIN_BITS-1:0] map_lines(input logic [MAP_LINES-1:0] lines);
      logic [PIN_BITS-1:0] pins;
      pins = '0;
      for (int k = 0; k < MAP_LINES; k++) begin
         if (lines[k]) begin
            pins[PIN_MAP[k]] = 1'b1;
         end
      end
      return pins;
   endfunction

   // driven lines: column high plus row low, diagonal uses the extra line
   function automatic logic [PIN_BITS-1:0] drive_enable(input logic [COORD_BITS-1:0] row,
                                                        input logic [COORD_BITS-1:0] col);
      logic [MAP_LINES-1:0] lines;
      if (row == col) begin
         lines = (MAP_LINES'(1) << col) | (MAP_LINES'(1) << GRID_SIZE);
      end else begin
         lines = (MAP_LINES'(1) << col) | (MAP_LINES'(1) << row);
      end
      return map_lines(lines);
   endfunction

   // levels: every line high except the row line; on the diagonal only the extra line is high
   function automatic logic [PIN_BITS-1:0] drive_level(input logic [COORD_BITS-1:0] row,
                                                       input logic [COORD_BITS-1:0] col);
      logic [MAP_LINES-1:0] lines;
      if (row == col) begin
         lines = MAP_LINES'(1) << GRID_SIZE;
      end else begin
         lines = ~(MAP_LINES'(1) << row);
      end
      return map_lines(lines);
   endfunction

endpackage

/* hdl/cpls_ram.sv */
// generic single write port ram with registered read
// no dependencies
module cpls_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 100
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

/* hdl/cpls_divider.sv */
// shared restoring divider, one quotient bit per cycle
// depends on cpls_pkg
module cpls_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  cpls_pkg::div_ctrl_type             ctrl,
   output cpls_pkg::div_status_type           status,
   output logic [cpls_pkg::DIVIDEND_BITS-1:0] quotient,
   output logic [cpls_pkg::DIVISOR_BITS-1:0]  remainder
);

   logic [cpls_pkg::DIVIDEND_BITS-1:0] quo_ff;
   logic [cpls_pkg::DIVISOR_BITS-1:0]  rem_ff;
   logic [cpls_pkg::DIVISOR_BITS-1:0]  den_ff;
   logic [cpls_pkg::DIV_STEP_BITS-1:0] step_ff;
   logic                               busy_ff;
   logic                               done_ff;

   logic [cpls_pkg::DIVISOR_BITS:0]    shifted;
   logic [cpls_pkg::DIVISOR_BITS:0]    diff;
   logic                               qbit;
   logic [cpls_pkg::DIVISOR_BITS-1:0]  rem_in;
   logic                               last_step;

   // one trial subtraction
   always_comb begin
      shifted = {rem_ff, quo_ff[cpls_pkg::DIVIDEND_BITS-1]};
      diff    = shifted - {1'b0, den_ff};
      qbit    = (shifted >= {1'b0, den_ff});
      rem_in  = qbit ? diff[cpls_pkg::DIVISOR_BITS-1:0]
                     : shifted[cpls_pkg::DIVISOR_BITS-1:0];
   end

   assign last_step = (step_ff == cpls_pkg::DIV_STEP_BITS'(cpls_pkg::DIVIDEND_BITS - 1));

   // iteration control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= !ctrl.start && busy_ff && last_step;
         if (ctrl.start) begin
            quo_ff  <= ctrl.dividend;
            rem_ff  <= '0;
            den_ff  <= ctrl.divisor;
            step_ff <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            quo_ff  <= {quo_ff[cpls_pkg::DIVIDEND_BITS-2:0], qbit};
            step_ff <= step_ff + cpls_pkg::DIV_STEP_BITS'(1);
            if (last_step) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule

/* hdl/charlieplex_lit_list_scanner.sv */
// double-buffered 10x10 charlieplexed scanner: pixel writes, commits, scan ticks
// write: no result; commit: report result after the frame walk and the divide
// tick: scan result after the divider modulo and the list read; neither when none lit
// one item in flight; a finished result waits in the output register while the next is taken
// reset is synchronous active high: frames read as off, budget 137, count and position zero
// depends on cpls_pkg, cpls_ram, cpls_divider and the macros header
`include "charlieplex_lit_list_scanner_macros.svh"

module charlieplex_lit_list_scanner (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_write_enable,
   input  logic [cpls_pkg::BUDGET_BITS-1:0]      csr_write_data,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [cpls_pkg::OP_BITS-1:0]          req_operation,
   input  logic [cpls_pkg::PIXEL_INDEX_BITS-1:0] req_pixel_index,
   input  logic                                  req_pixel_value,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_result_kind,
   output logic [cpls_pkg::PIN_BITS-1:0]         rsp_pin_drive_enable,
   output logic [cpls_pkg::PIN_BITS-1:0]         rsp_pin_drive_level,
   output logic [cpls_pkg::BUDGET_BITS-1:0]      rsp_scan_period,
   output logic [cpls_pkg::LIT_TOTAL_BITS-1:0]   rsp_lit_total
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_LREAD,
      ST_LDATA,
      ST_OUT
   } state_type;

   state_type                            state_ff;
   logic [cpls_pkg::BUDGET_BITS-1:0]     budget_ff;
   logic                                 front_select_ff;
   logic [cpls_pkg::COUNT_BITS-1:0]      lit_count_ff;
   logic [cpls_pkg::COUNT_BITS-1:0]      scan_pos_ff;
   logic [cpls_pkg::CELLS-1:0]           valid_a_ff;
   logic [cpls_pkg::CELLS-1:0]           valid_b_ff;
   logic                                 is_tick_ff;

   // frame walk
   logic [cpls_pkg::CELL_BITS-1:0]       cell_ff;
   logic [cpls_pkg::COORD_BITS-1:0]      row_ff;
   logic [cpls_pkg::COORD_BITS-1:0]      col_ff;
   logic                                 rd_pend_ff;
   logic                                 rd_valid_ff;
   logic [cpls_pkg::ENTRY_BITS-1:0]      rd_entry_ff;
   logic [cpls_pkg::COUNT_BITS-1:0]      lit_n_ff;

   // pending result
   logic                                 res_kind_ff;
   logic [cpls_pkg::PIN_BITS-1:0]        res_enable_ff;
   logic [cpls_pkg::PIN_BITS-1:0]        res_level_ff;
   logic [cpls_pkg::BUDGET_BITS-1:0]     res_period_ff;
   logic [cpls_pkg::LIT_TOTAL_BITS-1:0]  res_total_ff;

   // output register
   logic                                 rsp_valid_ff;
   logic                                 rsp_kind_ff;
   logic [cpls_pkg::PIN_BITS-1:0]        rsp_enable_ff;
   logic [cpls_pkg::PIN_BITS-1:0]        rsp_level_ff;
   logic [cpls_pkg::BUDGET_BITS-1:0]     rsp_period_ff;
   logic [cpls_pkg::LIT_TOTAL_BITS-1:0]  rsp_total_ff;

   logic                                 req_fire;
   logic                                 write_fire;
   logic                                 frame_a_q;
   logic                                 frame_b_q;
   logic                                 shown_bit;
   logic                                 lit_we;
   logic [cpls_pkg::ENTRY_BITS-1:0]      lit_q;
   logic [cpls_pkg::COORD_BITS-1:0]      lit_row;
   logic [cpls_pkg::COORD_BITS-1:0]      lit_col;
   logic                                 commit_empty;

   cpls_pkg::div_ctrl_type               div_ctrl;
   cpls_pkg::div_status_type             div_status;
   logic [cpls_pkg::DIVIDEND_BITS-1:0]   div_quotient;
   logic [cpls_pkg::DIVISOR_BITS-1:0]    div_remainder;

   // request handshake and back-frame write decode
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_fire   = req_valid && !req_stall;
   assign write_fire = req_fire
                    && (cpls_pkg::op_type'(req_operation) == cpls_pkg::OP_WRITE)
                    && (req_pixel_index
                        < cpls_pkg::PIXEL_INDEX_BITS'(cpls_pkg::CELLS));

   // frame stores, back frame is a when front_select is zero
   cpls_ram #(.WIDTH(1), .DEPTH(cpls_pkg::CELLS)) u_frame_a (
      .clock         (clock),
      .write_enable  (write_fire && !front_select_ff),
      .write_address (req_pixel_index[cpls_pkg::CELL_BITS-1:0]),
      .write_data    (req_pixel_value),
      .read_address  (cell_ff),
      .read_data     (frame_a_q)
   );

   cpls_ram #(.WIDTH(1), .DEPTH(cpls_pkg::CELLS)) u_frame_b (
      .clock         (clock),
      .write_enable  (write_fire && front_select_ff),
      .write_address (req_pixel_index[cpls_pkg::CELL_BITS-1:0]),
      .write_data    (req_pixel_value),
      .read_address  (cell_ff),
      .read_data     (frame_b_q)
   );

   // lit cell of the walk, unwritten frame cells read as off
   assign shown_bit = rd_valid_ff && (front_select_ff ? frame_a_q : frame_b_q);
   assign lit_we    = rd_pend_ff && shown_bit;

   // lit list store
   cpls_ram #(.WIDTH(cpls_pkg::ENTRY_BITS), .DEPTH(cpls_pkg::CELLS)) u_lit_list (
      .clock         (clock),
      .write_enable  (lit_we),
      .write_address (lit_n_ff[cpls_pkg::CELL_BITS-1:0]),
      .write_data    (rd_entry_ff),
      .read_address  (scan_pos_ff[cpls_pkg::CELL_BITS-1:0]),
      .read_data     (lit_q)
   );

   assign lit_row = lit_q[cpls_pkg::ENTRY_BITS-1:cpls_pkg::COORD_BITS];
   assign lit_col = lit_q[cpls_pkg::COORD_BITS-1:0];

   // shared divider: budget over count on commit, position step modulo count on tick
   assign commit_empty = !is_tick_ff && (lit_n_ff == '0);

   always_comb begin
      div_ctrl.start    = (state_ff == ST_DIV_GO) && !commit_empty;
      div_ctrl.dividend = is_tick_ff
                        ? cpls_pkg::DIVIDEND_BITS'(scan_pos_ff)
                          + cpls_pkg::DIVIDEND_BITS'(1)
                        : budget_ff;
      div_ctrl.divisor  = is_tick_ff ? lit_count_ff : lit_n_ff;
   end

   cpls_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .status    (div_status),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // sequencer and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         budget_ff       <= cpls_pkg::PERIOD_RESET;
         front_select_ff <= 1'b0;
         lit_count_ff    <= '0;
         scan_pos_ff     <= '0;
         valid_a_ff      <= '0;
         valid_b_ff      <= '0;
         rd_pend_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            budget_ff <= csr_write_data;
         end

         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         // mark back-frame cells as written
         if (write_fire) begin
            if (front_select_ff) begin
               valid_b_ff[req_pixel_index[cpls_pkg::CELL_BITS-1:0]] <= 1'b1;
            end else begin
               valid_a_ff[req_pixel_index[cpls_pkg::CELL_BITS-1:0]] <= 1'b1;
            end
         end

         // count lit cells as the frame data returns
         rd_pend_ff <= (state_ff == ST_WALK);
         if (lit_we) begin
            lit_n_ff <= lit_n_ff + cpls_pkg::COUNT_BITS'(1);
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  unique case (cpls_pkg::op_type'(req_operation))
                     cpls_pkg::OP_COMMIT: begin
                        front_select_ff <= ~front_select_ff;
                        cell_ff         <= '0;
                        row_ff          <= '0;
                        col_ff          <= '0;
                        lit_n_ff        <= '0;
                        is_tick_ff      <= 1'b0;
                        state_ff        <= ST_WALK;
                     end
                     cpls_pkg::OP_TICK: begin
                        is_tick_ff <= 1'b1;
                        if (lit_count_ff == '0) begin
                           res_kind_ff   <= cpls_pkg::RES_SCAN;
                           res_enable_ff <= '0;
                           res_level_ff  <= '0;
                           res_period_ff <= '0;
                           res_total_ff  <= '0;
                           state_ff      <= ST_OUT;
                        end else begin
                           state_ff <= ST_DIV_GO;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end

            ST_WALK: begin
               rd_valid_ff <= front_select_ff ? valid_a_ff[cell_ff] : valid_b_ff[cell_ff];
               rd_entry_ff <= {row_ff, col_ff};
               cell_ff     <= cell_ff + cpls_pkg::CELL_BITS'(1);
               if (col_ff == cpls_pkg::COORD_BITS'(cpls_pkg::GRID_SIZE - 1)) begin
                  col_ff <= '0;
                  row_ff <= row_ff + cpls_pkg::COORD_BITS'(1);
               end else begin
                  col_ff <= col_ff + cpls_pkg::COORD_BITS'(1);
               end
               if (cell_ff == cpls_pkg::CELL_BITS'(cpls_pkg::CELLS - 1)) begin
                  state_ff <= ST_DRAIN;
               end
            end

            ST_DRAIN: begin
               state_ff <= ST_DIV_GO;
            end

            ST_DIV_GO: begin
               if (!is_tick_ff) begin
                  lit_count_ff <= lit_n_ff;
               end
               if (commit_empty) begin
                  res_kind_ff   <= cpls_pkg::RES_REPORT;
                  res_enable_ff <= '0;
                  res_level_ff  <= '0;
                  res_period_ff <= budget_ff;
                  res_total_ff  <= '0;
                  state_ff      <= ST_OUT;
               end else begin
                  state_ff <= ST_DIV_WAIT;
               end
            end

            ST_DIV_WAIT: begin
               if (div_status.done) begin
                  if (is_tick_ff) begin
                     scan_pos_ff <= div_remainder;
                     state_ff    <= ST_LREAD;
                  end else begin
                     res_kind_ff   <= cpls_pkg::RES_REPORT;
                     res_enable_ff <= '0;
                     res_level_ff  <= '0;
                     res_period_ff <= div_quotient;
                     res_total_ff  <= cpls_pkg::LIT_TOTAL_BITS'(lit_count_ff);
                     state_ff      <= ST_OUT;
                  end
               end
            end

            ST_LREAD: begin
               state_ff <= ST_LDATA;
            end

            ST_LDATA: begin
               res_kind_ff   <= cpls_pkg::RES_SCAN;
               res_enable_ff <= cpls_pkg::drive_enable(lit_row, lit_col);
               res_level_ff  <= cpls_pkg::drive_level(lit_row, lit_col);
               res_period_ff <= '0;
               res_total_ff  <= '0;
               state_ff      <= ST_OUT;
            end

            ST_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_kind_ff   <= res_kind_ff;
                  rsp_enable_ff <= res_enable_ff;
                  rsp_level_ff  <= res_level_ff;
                  rsp_period_ff <= res_period_ff;
                  rsp_total_ff  <= res_total_ff;
                  state_ff      <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_result_kind      = rsp_kind_ff;
   assign rsp_pin_drive_enable = rsp_enable_ff;
   assign rsp_pin_drive_level  = rsp_level_ff;
   assign rsp_scan_period      = rsp_period_ff;
   assign rsp_lit_total        = rsp_total_ff;

   // checks
   `CPLS_ASSERT_IMPL(a_div_start_idle, div_ctrl.start, !div_status.busy)
   `CPLS_ASSERT_IMPL(a_pos_in_list, state_ff == ST_LDATA, scan_pos_ff < lit_count_ff)
   `CPLS_ASSERT_IMPL(a_scan_result_clean,
                     rsp_valid_ff && (rsp_kind_ff == cpls_pkg::RES_SCAN),
                     (rsp_period_ff == '0) && (rsp_total_ff == '0))
   `CPLS_ASSERT_NEXT(a_walk_ends_in_drain,
                     (state_ff == ST_WALK)
                     && (cell_ff == cpls_pkg::CELL_BITS'(cpls_pkg::CELLS - 1)),
                     state_ff == ST_DRAIN)

endmodule

/* test/lit_scan_checker.sv */
`timescale 1ns / 100ps
// lit_scan_checker: watches the register, request and response ports of the scanner and
// predicts every response from its own copy of the frames, lit list and scan position
// depends on cpls_pkg for field widths, operation codes and result kinds
module lit_scan_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [cpls_pkg::BUDGET_BITS-1:0] csr_write_data,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [cpls_pkg::OP_BITS-1:0]  req_operation,
   input  logic [cpls_pkg::PIXEL_INDEX_BITS-1:0] req_pixel_index,
   input  logic                          req_pixel_value,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          rsp_result_kind,
   input  logic [cpls_pkg::PIN_BITS-1:0] rsp_pin_drive_enable,
   input  logic [cpls_pkg::PIN_BITS-1:0] rsp_pin_drive_level,
   input  logic [cpls_pkg::BUDGET_BITS-1:0] rsp_scan_period,
   input  logic [cpls_pkg::LIT_TOTAL_BITS-1:0] rsp_lit_total,
   output int                            fail_count,
   output int                            outstanding,
   output int                            checked
);

   localparam logic [cpls_pkg::BUDGET_BITS-1:0] BUDGET_AFTER_RESET = 8'd137;

   typedef struct packed {
      logic                                kind;
      logic [cpls_pkg::PIN_BITS-1:0]       enable;
      logic [cpls_pkg::PIN_BITS-1:0]       level;
      logic [cpls_pkg::BUDGET_BITS-1:0]    period;
      logic [cpls_pkg::LIT_TOTAL_BITS-1:0] total;
   } scan_result_type;

   // predicted scanner state
   logic [cpls_pkg::CELLS-1:0]       frame_a;
   logic [cpls_pkg::CELLS-1:0]       frame_b;
   logic                             showing_a;
   logic [7:0]                       lit_cells [cpls_pkg::CELLS];
   int                               lit_count;
   int                               scan_pos;
   logic [cpls_pkg::BUDGET_BITS-1:0] budget;
   scan_result_type                  results_due [$];

   // drive lines 0..10 land on pins 0,1,2,6,7,10..15
   function automatic logic [cpls_pkg::PIN_BITS-1:0] pins_of(input logic [10:0] lines);
      return {lines[10:5], 2'b00, lines[4:3], 3'b000, lines[2:0]};
   endfunction

   // advance the predicted state by one request transfer
   task automatic take_request(input logic [cpls_pkg::OP_BITS-1:0] op,
                               input logic [cpls_pkg::PIXEL_INDEX_BITS-1:0] idx,
                               input logic val);
      scan_result_type            res;
      logic [cpls_pkg::CELLS-1:0] shown;
      logic [3:0]                 row;
      logic [3:0]                 col;
      logic [10:0]                en_lines;
      logic [10:0]                lv_lines;
      res = '0;
      case (op)
         cpls_pkg::OP_WRITE: begin
            // out-of-grid writes fall away
            if (idx < cpls_pkg::CELLS) begin
               if (showing_a) begin
                  frame_b[idx] = val;
               end else begin
                  frame_a[idx] = val;
               end
            end
         end
         cpls_pkg::OP_COMMIT: begin
            // swap frames and rebuild the row-major lit list
            showing_a = !showing_a;
            shown = showing_a ? frame_a : frame_b;
            lit_count = 0;
            for (int r = 0; r < cpls_pkg::GRID_SIZE; r++) begin
               for (int c = 0; c < cpls_pkg::GRID_SIZE; c++) begin
                  if (shown[r * cpls_pkg::GRID_SIZE + c]) begin
                     lit_cells[lit_count] = {4'(r), 4'(c)};
                     lit_count++;
                  end
               end
            end
            res.kind = cpls_pkg::RES_REPORT;
            res.period = (lit_count == 0) ? budget
                                          : cpls_pkg::BUDGET_BITS'(budget / lit_count);
            res.total = cpls_pkg::LIT_TOTAL_BITS'(lit_count);
            results_due.push_back(res);
         end
         cpls_pkg::OP_TICK: begin
            // dark frame: pins stay off and the position holds
            res.kind = cpls_pkg::RES_SCAN;
            if (lit_count != 0) begin
               scan_pos = (scan_pos + 1) % lit_count;
               row = lit_cells[scan_pos][7:4];
               col = lit_cells[scan_pos][3:0];
               if (row == col) begin
                  lv_lines = 11'b1 << cpls_pkg::GRID_SIZE;
                  en_lines = (11'b1 << col) | (11'b1 << cpls_pkg::GRID_SIZE);
               end else begin
                  lv_lines = ~(11'b1 << row);
                  en_lines = (11'b1 << col) | (11'b1 << row);
               end
               res.enable = pins_of(en_lines);
               res.level = pins_of(lv_lines);
            end
            results_due.push_back(res);
         end
         default: begin
            // unused operation code: no effect
         end
      endcase
   endtask

   task automatic check_field(input string field, input logic [cpls_pkg::PIN_BITS-1:0] want,
                              input logic [cpls_pkg::PIN_BITS-1:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   // sample all ports at the rising edge
   always @(posedge clock) begin
      scan_result_type want;
      if (reset) begin
         frame_a = '0;
         frame_b = '0;
         showing_a = 1'b0;
         lit_count = 0;
         scan_pos = 0;
         budget = BUDGET_AFTER_RESET;
         results_due.delete();
         fail_count = 0;
         checked = 0;
      end else begin
         if (csr_write_enable) begin
            budget = csr_write_data;
         end
         // response transfer belongs to an earlier request, so compare first
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (results_due.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response, expected none, actual kind %0b",
                        $time, rsp_result_kind);
            end else begin
               want = results_due.pop_front();
               check_field("result_kind", want.kind, rsp_result_kind);
               check_field("pin_drive_enable", want.enable, rsp_pin_drive_enable);
               check_field("pin_drive_level", want.level, rsp_pin_drive_level);
               check_field("scan_period", want.period, rsp_scan_period);
               check_field("lit_total", want.total, rsp_lit_total);
            end
         end
         if (req_valid && !req_stall) begin
            take_request(req_operation, req_pixel_index, req_pixel_value);
         end
      end
      outstanding = results_due.size();
   end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// testbench: clock, reset, register writes and request/response stimulus for the scanner
// depends on cpls_pkg, charlieplex_lit_list_scanner and lit_scan_checker
module testbench;

   localparam logic [cpls_pkg::OP_BITS-1:0] OP_UNUSED = 2'd3;
   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 9;
   localparam int SETTLE_CYCLES = 150;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 210;

   logic                                  clock;
   logic                                  reset;
   logic                                  csr_write_enable;
   logic [cpls_pkg::BUDGET_BITS-1:0]      csr_write_data;
   logic                                  req_valid;
   logic                                  req_stall;
   logic [cpls_pkg::OP_BITS-1:0]          req_operation;
   logic [cpls_pkg::PIXEL_INDEX_BITS-1:0] req_pixel_index;
   logic                                  req_pixel_value;
   logic                                  rsp_valid;
   logic                                  rsp_stall;
   logic                                  rsp_result_kind;
   logic [cpls_pkg::PIN_BITS-1:0]         rsp_pin_drive_enable;
   logic [cpls_pkg::PIN_BITS-1:0]         rsp_pin_drive_level;
   logic [cpls_pkg::BUDGET_BITS-1:0]      rsp_scan_period;
   logic [cpls_pkg::LIT_TOTAL_BITS-1:0]   rsp_lit_total;

   int fail_count;
   int outstanding;
   int checked;
   int cycles;
   int items_sent;
   int sent [4];
   bit calm;

   charlieplex_lit_list_scanner DUT (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_pixel_index      (req_pixel_index),
      .req_pixel_value      (req_pixel_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_pin_drive_enable (rsp_pin_drive_enable),
      .rsp_pin_drive_level  (rsp_pin_drive_level),
      .rsp_scan_period      (rsp_scan_period),
      .rsp_lit_total        (rsp_lit_total)
   );

   lit_scan_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_pixel_index      (req_pixel_index),
      .req_pixel_value      (req_pixel_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_pin_drive_enable (rsp_pin_drive_enable),
      .rsp_pin_drive_level  (rsp_pin_drive_level),
      .rsp_scan_period      (rsp_scan_period),
      .rsp_lit_total        (rsp_lit_total),
      .fail_count           (fail_count),
      .outstanding          (outstanding),
      .checked              (checked)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still due", cycles, outstanding);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // response side stalls in short bursts, none in the calm tail
   initial begin
      rsp_stall = 1'b0;
      forever begin
         repeat ($urandom_range(1, 12)) @(negedge clock);
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   // present one request at a falling edge and hold it until the transfer
   task automatic send_item(input logic [cpls_pkg::OP_BITS-1:0] op,
                            input logic [cpls_pkg::PIXEL_INDEX_BITS-1:0] idx,
                            input logic val);
      req_operation = op;
      req_pixel_index = idx;
      req_pixel_value = val;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent[op]++;
      if (op != OP_UNUSED && !(op == cpls_pkg::OP_WRITE && idx >= cpls_pkg::CELLS)) begin
         items_sent++;
      end
      @(negedge clock);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   endtask

   // drain all responses, let trailing writes finish, then load a new budget
   task automatic set_budget(input logic [cpls_pkg::BUDGET_BITS-1:0] value);
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_data = value;
      csr_write_enable = 1'b1;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // a few back-frame writes, a commit, then a run of ticks, with some noise
   task automatic frame_burst();
      int writes;
      int density;
      int ticks;
      logic fill;
      writes = $urandom_range(0, 10);
      density = $urandom_range(0, 4);
      if ($urandom_range(0, 29) == 0) begin
         // whole-frame fill or clear
         fill = ($urandom_range(0, 2) != 0);
         for (int k = 0; k < cpls_pkg::CELLS; k++) begin
            send_item(cpls_pkg::OP_WRITE, cpls_pkg::PIXEL_INDEX_BITS'(k), fill);
         end
      end else begin
         for (int k = 0; k < writes; k++) begin
            if ($urandom_range(0, 7) == 0) begin
               send_item(cpls_pkg::OP_WRITE,
                         cpls_pkg::PIXEL_INDEX_BITS'($urandom_range(cpls_pkg::CELLS, 127)),
                         1'($urandom_range(0, 1)));
            end else begin
               send_item(cpls_pkg::OP_WRITE,
                         cpls_pkg::PIXEL_INDEX_BITS'($urandom_range(0, cpls_pkg::CELLS - 1)),
                         $urandom_range(0, 3) < density);
            end
         end
      end
      if ($urandom_range(0, 19) == 0) begin
         send_item(OP_UNUSED, cpls_pkg::PIXEL_INDEX_BITS'($urandom_range(0, 127)),
                   1'($urandom_range(0, 1)));
      end
      // now and then skip the commit so ticks scan a stale list
      if ($urandom_range(0, 9) != 0) begin
         send_item(cpls_pkg::OP_COMMIT, cpls_pkg::PIXEL_INDEX_BITS'($urandom_range(0, 127)),
                   1'($urandom_range(0, 1)));
      end
      ticks = $urandom_range(0, 12);
      for (int k = 0; k < ticks; k++) begin
         send_item(cpls_pkg::OP_TICK, cpls_pkg::PIXEL_INDEX_BITS'($urandom_range(0, 127)),
                   1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      logic [cpls_pkg::BUDGET_BITS-1:0] budget;
      reset = 1'b1;
      calm = 1'b0;
      req_valid = 1'b0;
      req_operation = cpls_pkg::OP_WRITE;
      req_pixel_index = '0;
      req_pixel_value = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed part under the reset budget
      // tick and commit with nothing lit
      send_item(cpls_pkg::OP_TICK, 7'd0, 1'b0);
      send_item(cpls_pkg::OP_COMMIT, 7'd0, 1'b0);
      send_item(OP_UNUSED, 7'd127, 1'b1);
      // out-of-grid writes
      send_item(cpls_pkg::OP_WRITE, 7'd127, 1'b1);
      send_item(cpls_pkg::OP_WRITE, 7'd100, 1'b1);
      // both diagonal corners, the off-diagonal corners and an inner cell
      send_item(cpls_pkg::OP_WRITE, 7'd0, 1'b1);
      send_item(cpls_pkg::OP_WRITE, 7'd99, 1'b1);
      send_item(cpls_pkg::OP_WRITE, 7'd9, 1'b1);
      send_item(cpls_pkg::OP_WRITE, 7'd90, 1'b1);
      send_item(cpls_pkg::OP_WRITE, 7'd45, 1'b1);
      send_item(cpls_pkg::OP_COMMIT, 7'd0, 1'b0);
      // walk the list past its wrap
      for (int k = 0; k < 6; k++) begin
         send_item(cpls_pkg::OP_TICK, 7'd0, 1'b0);
      end
      // set and clear a cell, leave one lit; position carries over the commit
      send_item(cpls_pkg::OP_WRITE, 7'd64, 1'b1);
      send_item(cpls_pkg::OP_WRITE, 7'd64, 1'b0);
      send_item(cpls_pkg::OP_WRITE, 7'd37, 1'b1);
      send_item(cpls_pkg::OP_COMMIT, 7'd0, 1'b0);
      send_item(cpls_pkg::OP_TICK, 7'd0, 1'b0);
      send_item(cpls_pkg::OP_COMMIT, 7'd0, 1'b0);
      send_item(cpls_pkg::OP_TICK, 7'd0, 1'b0);
      send_item(cpls_pkg::OP_TICK, 7'd0, 1'b0);

      // random phases, each under its own budget, extremes first
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: budget = 8'd255;
            1: budget = 8'd0;
            2: budget = 8'd1;
            default: budget = cpls_pkg::BUDGET_BITS'($urandom_range(2, 254));
         endcase
         set_budget(budget);
         calm = (phase == PHASES - 1);
         items_sent = 0;
         while (items_sent < PHASE_ITEMS) frame_burst();
      end

      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("sent %0d writes, %0d commits, %0d ticks, %0d unused codes over %0d budgets",
               sent[cpls_pkg::OP_WRITE], sent[cpls_pkg::OP_COMMIT], sent[cpls_pkg::OP_TICK],
               sent[OP_UNUSED], PHASES + 1);
      $display("compared %0d response transfers, %0d failures", checked, fail_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
